[rtl/fcxm_pkg.sv]
package fcxm_pkg;

	localparam int ANGLE_BITS     = 12;
	localparam int GAIN_FRAC_BITS = 8;
	localparam int TRIG_BITS      = 14;
	localparam int DRIVE_MAX      = 127;

	localparam int AXIS_W = 8;
	localparam int GAIN_W = GAIN_FRAC_BITS + 1;
	localparam int TRIG_W = TRIG_BITS + 2;            // signed Q1.14
	localparam int XW     = AXIS_W + GAIN_W;          // scaled axis, signed
	localparam int MUL_W  = XW + 1;                   // shared multiplier operand
	localparam int PW     = 2 * MUL_W;
	localparam int AW     = XW + TRIG_BITS + 3;       // rotation accumulators
	localparam int SW     = AW + 2;                   // three-term drive sums
	localparam int SH     = GAIN_FRAC_BITS + TRIG_BITS;

	localparam int IN_BITS = 3 * AXIS_W + ANGLE_BITS + 1;
	localparam int IN_W    = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_W   = 4 * AXIS_W;

	localparam int PADDR_W = 4;
	localparam logic [1:0] REG_FCE  = 2'd0;
	localparam logic [1:0] REG_SLOW = 2'd1;
	localparam logic [1:0] REG_FULL = 2'd2;

	localparam int STEP_W = 4;

	typedef enum logic [2:0] {A_LX, A_LY, A_RX, A_X, A_Y, A_R, A_D} a_sel_t;
	typedef enum logic [2:0] {B_GAIN, B_CQ, B_SQ, B_FRAC, B_ONE} b_sel_t;
	typedef enum logic [3:0] {
		D_NONE, D_X, D_Y, D_R, D_SIN, D_COS,
		D_FX_LD, D_FX_SUB, D_FY_LD, D_FY_ADD, D_RR
	} dst_t;
	typedef enum logic [1:0] {C_NONE, C_WAIT_IN, C_WAIT_OUT} cond_t;

	typedef struct packed {
		a_sel_t            a_sel;
		b_sel_t            b_sel;
		dst_t              dst;
		cond_t             cond;
		logic              emit;
		logic [STEP_W-1:0] next;
	} ucode_t;

	typedef struct packed {
		a_sel_t a_sel;
		b_sel_t b_sel;
		dst_t   dst;
		logic   emit;       // load output register this cycle
		logic   in_ready;
	} ctrl_t;

	typedef struct packed {
		logic [14:0] base;
		logic [9:0]  d;
		logic [8:0]  frac;
		logic        neg;
	} trig_t;

	// round(16384*sin(k*pi/64)), k = 0..32
	function automatic logic [14:0] sine_tab(input logic [5:0] k);
		logic [14:0] v;
		case (k)
			6'd0:  v = 15'd0;     6'd1:  v = 15'd804;   6'd2:  v = 15'd1606;
			6'd3:  v = 15'd2404;  6'd4:  v = 15'd3196;  6'd5:  v = 15'd3981;
			6'd6:  v = 15'd4756;  6'd7:  v = 15'd5520;  6'd8:  v = 15'd6270;
			6'd9:  v = 15'd7005;  6'd10: v = 15'd7723;  6'd11: v = 15'd8423;
			6'd12: v = 15'd9102;  6'd13: v = 15'd9760;  6'd14: v = 15'd10394;
			6'd15: v = 15'd11003; 6'd16: v = 15'd11585; 6'd17: v = 15'd12140;
			6'd18: v = 15'd12665; 6'd19: v = 15'd13160; 6'd20: v = 15'd13623;
			6'd21: v = 15'd14053; 6'd22: v = 15'd14449; 6'd23: v = 15'd14811;
			6'd24: v = 15'd15137; 6'd25: v = 15'd15426; 6'd26: v = 15'd15679;
			6'd27: v = 15'd15893; 6'd28: v = 15'd16069; 6'd29: v = 15'd16207;
			6'd30: v = 15'd16305; 6'd31: v = 15'd16364;
			default: v = 15'd16384;
		endcase
		return v;
	endfunction

endpackage

[rtl/fcxm_trig.sv]
// Quarter-wave sine lookup: base point, step to next point, fraction, sign.
module fcxm_trig (
	input  logic [15:0]    angle,
	output fcxm_pkg::trig_t trig
);

	logic [14:0] q;
	logic [5:0]  idx;
	logic [14:0] t0, t1;

	always_comb begin
		q = {1'b0, angle[13:0]};
		if (angle[14]) begin
			q = 15'd16384 - q;
		end
		idx = q[14:9];
		t0  = fcxm_pkg::sine_tab(idx);
		t1  = fcxm_pkg::sine_tab(idx + 6'd1);
		trig.base = t0;
		trig.d    = (idx >= 6'd32) ? 10'd0 : 10'(t1 - t0);
		trig.frac = q[8:0];
		trig.neg  = angle[15];
	end

endmodule

[rtl/fcxm_seq.sv]
// Microcode ROM and step counter.
module fcxm_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               out_busy,
	output fcxm_pkg::ctrl_t    ctrl
);

	logic [fcxm_pkg::STEP_W-1:0] step_q;
	fcxm_pkg::ucode_t            uw;
	logic                        hold;

	// one control word per step
	always_comb begin
		uw = '{a_sel: fcxm_pkg::A_LX, b_sel: fcxm_pkg::B_GAIN, dst: fcxm_pkg::D_NONE,
		       cond: fcxm_pkg::C_NONE, emit: 1'b0, next: step_q + 4'd1};
		unique case (step_q)
			4'd0: uw.cond = fcxm_pkg::C_WAIT_IN;
			4'd1: begin
				uw.a_sel = fcxm_pkg::A_LX; uw.b_sel = fcxm_pkg::B_GAIN; uw.dst = fcxm_pkg::D_X;
			end
			4'd2: begin
				uw.a_sel = fcxm_pkg::A_LY; uw.b_sel = fcxm_pkg::B_GAIN; uw.dst = fcxm_pkg::D_Y;
			end
			4'd3: begin
				uw.a_sel = fcxm_pkg::A_RX; uw.b_sel = fcxm_pkg::B_GAIN; uw.dst = fcxm_pkg::D_R;
			end
			4'd4: begin
				uw.a_sel = fcxm_pkg::A_D; uw.b_sel = fcxm_pkg::B_FRAC; uw.dst = fcxm_pkg::D_SIN;
			end
			4'd5: begin
				uw.a_sel = fcxm_pkg::A_D; uw.b_sel = fcxm_pkg::B_FRAC; uw.dst = fcxm_pkg::D_COS;
			end
			4'd6: begin
				uw.a_sel = fcxm_pkg::A_X; uw.b_sel = fcxm_pkg::B_CQ; uw.dst = fcxm_pkg::D_FX_LD;
			end
			4'd7: begin
				uw.a_sel = fcxm_pkg::A_Y; uw.b_sel = fcxm_pkg::B_SQ; uw.dst = fcxm_pkg::D_FX_SUB;
			end
			4'd8: begin
				uw.a_sel = fcxm_pkg::A_X; uw.b_sel = fcxm_pkg::B_SQ; uw.dst = fcxm_pkg::D_FY_LD;
			end
			4'd9: begin
				uw.a_sel = fcxm_pkg::A_Y; uw.b_sel = fcxm_pkg::B_CQ; uw.dst = fcxm_pkg::D_FY_ADD;
			end
			4'd10: begin
				uw.a_sel = fcxm_pkg::A_R; uw.b_sel = fcxm_pkg::B_ONE; uw.dst = fcxm_pkg::D_RR;
			end
			4'd11: begin
				uw.cond = fcxm_pkg::C_WAIT_OUT; uw.emit = 1'b1; uw.next = 4'd0;
			end
			default: uw.next = 4'd0;
		endcase
	end

	always_comb begin
		unique case (uw.cond)
			fcxm_pkg::C_WAIT_IN:  hold = !in_valid;
			fcxm_pkg::C_WAIT_OUT: hold = out_busy;
			default:              hold = 1'b0;
		endcase
	end

	always_comb begin
		ctrl.a_sel    = uw.a_sel;
		ctrl.b_sel    = uw.b_sel;
		ctrl.dst      = uw.dst;
		ctrl.emit     = uw.emit && !hold;
		ctrl.in_ready = (uw.cond == fcxm_pkg::C_WAIT_IN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (!hold) begin
			step_q <= uw.next;
		end
	end

endmodule

[rtl/fcxm_dp.sv]
// Datapath: shared multiplier, scaled axes, trig values, accumulators, output register.
module fcxm_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  fcxm_pkg::ctrl_t                     ctrl,
	input  logic                                in_fire,
	input  logic [fcxm_pkg::IN_W-1:0]           in_data,
	input  logic [fcxm_pkg::GAIN_W-1:0]         gain,
	input  logic                                fce,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic [fcxm_pkg::OUT_W-1:0]          out_data
);

	localparam int AB = fcxm_pkg::AXIS_W;

	logic signed [AB-1:0]                 lx_q, ly_q, rx_q;
	logic [15:0]                          ang_q;
	logic signed [fcxm_pkg::XW-1:0]       x_q, y_q, r_q;
	logic signed [fcxm_pkg::TRIG_W-1:0]   s_q, c_q;
	logic signed [fcxm_pkg::AW-1:0]       fx_q, fy_q, rr_q;
	logic [fcxm_pkg::OUT_W-1:0]           drv_q;
	logic                                 vld_q;

	logic signed [fcxm_pkg::MUL_W-1:0]    op_a, op_b;
	logic signed [fcxm_pkg::PW-1:0]       prod;
	logic signed [fcxm_pkg::AW-1:0]       prod_a;
	logic [15:0]                          t_angle;
	fcxm_pkg::trig_t                      trig;
	logic [19:0]                          step_r;
	logic [14:0]                          t_mag;
	logic signed [fcxm_pkg::TRIG_W-1:0]   t_val;
	logic signed [fcxm_pkg::SW-1:0]       sum_fl, sum_fr, sum_bl, sum_br;
	logic [fcxm_pkg::OUT_W-1:0]           drv;

	function automatic logic [7:0] drive_out(input logic signed [fcxm_pkg::SW-1:0] v);
		logic [fcxm_pkg::SW-1:0] mag, rnd;
		logic [6:0]              m7;
		mag = v[fcxm_pkg::SW-1] ? fcxm_pkg::SW'(-v) : fcxm_pkg::SW'(v);
		rnd = (mag + (fcxm_pkg::SW'(1) << (fcxm_pkg::SH - 1))) >> fcxm_pkg::SH;
		m7  = (rnd > fcxm_pkg::SW'(fcxm_pkg::DRIVE_MAX)) ? 7'(fcxm_pkg::DRIVE_MAX)
		                                                 : rnd[6:0];
		return v[fcxm_pkg::SW-1] ? 8'(-{1'b0, m7}) : {1'b0, m7};
	endfunction

	// heading to 16-bit turn fraction; cosine is a quarter turn ahead
	always_comb begin
		t_angle = (ctrl.dst == fcxm_pkg::D_COS) ? ang_q + 16'd16384 : ang_q;
	end

	fcxm_trig u_trig (
		.angle (t_angle),
		.trig  (trig)
	);

	always_comb begin
		unique case (ctrl.a_sel)
			fcxm_pkg::A_LX: op_a = fcxm_pkg::MUL_W'(lx_q);
			fcxm_pkg::A_LY: op_a = fcxm_pkg::MUL_W'(ly_q);
			fcxm_pkg::A_RX: op_a = fcxm_pkg::MUL_W'(rx_q);
			fcxm_pkg::A_X:  op_a = fcxm_pkg::MUL_W'(x_q);
			fcxm_pkg::A_Y:  op_a = fcxm_pkg::MUL_W'(y_q);
			fcxm_pkg::A_R:  op_a = fcxm_pkg::MUL_W'(r_q);
			default:        op_a = signed'(fcxm_pkg::MUL_W'(trig.d));
		endcase
		unique case (ctrl.b_sel)
			fcxm_pkg::B_GAIN: op_b = signed'(fcxm_pkg::MUL_W'(gain));
			fcxm_pkg::B_CQ:   op_b = fcxm_pkg::MUL_W'(c_q);
			fcxm_pkg::B_SQ:   op_b = fcxm_pkg::MUL_W'(s_q);
			fcxm_pkg::B_FRAC: op_b = signed'(fcxm_pkg::MUL_W'(trig.frac));
			default:          op_b = signed'(fcxm_pkg::MUL_W'(1 << fcxm_pkg::TRIG_BITS));
		endcase
		prod   = op_a * op_b;
		prod_a = prod[fcxm_pkg::AW-1:0];
	end

	// interpolation: step rounded half up over 9 fraction bits
	always_comb begin
		step_r = (prod[19:0] + 20'd256) >> 9;
		t_mag  = trig.base + step_r[14:0];
		t_val  = trig.neg ? -signed'(fcxm_pkg::TRIG_W'(t_mag))
		                  : signed'(fcxm_pkg::TRIG_W'(t_mag));
	end

	always_comb begin
		sum_fl = fcxm_pkg::SW'(rr_q) + fcxm_pkg::SW'(fy_q) + fcxm_pkg::SW'(fx_q);
		sum_fr = fcxm_pkg::SW'(rr_q) - fcxm_pkg::SW'(fy_q) + fcxm_pkg::SW'(fx_q);
		sum_bl = fcxm_pkg::SW'(rr_q) + fcxm_pkg::SW'(fy_q) - fcxm_pkg::SW'(fx_q);
		sum_br = fcxm_pkg::SW'(rr_q) - fcxm_pkg::SW'(fy_q) - fcxm_pkg::SW'(fx_q);
		drv    = {drive_out(sum_br), drive_out(sum_bl), drive_out(sum_fr), drive_out(sum_fl)};
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			lx_q  <= signed'(in_data[AB-1:0]);
			ly_q  <= signed'(in_data[2*AB-1:AB]);
			rx_q  <= signed'(in_data[3*AB-1:2*AB]);
			ang_q <= 16'(in_data[3*AB +: fcxm_pkg::ANGLE_BITS]) << (16 - fcxm_pkg::ANGLE_BITS);
		end
		unique case (ctrl.dst)
			fcxm_pkg::D_X:      x_q  <= signed'(prod[fcxm_pkg::XW-1:0]);
			fcxm_pkg::D_Y:      y_q  <= signed'(prod[fcxm_pkg::XW-1:0]);
			fcxm_pkg::D_R:      r_q  <= signed'(prod[fcxm_pkg::XW-1:0]);
			fcxm_pkg::D_SIN:    s_q  <= fce ? t_val : '0;
			fcxm_pkg::D_COS:    c_q  <= fce ? t_val
			                                : signed'(fcxm_pkg::TRIG_W'(1 << fcxm_pkg::TRIG_BITS));
			fcxm_pkg::D_FX_LD:  fx_q <= prod_a;
			fcxm_pkg::D_FX_SUB: fx_q <= fx_q - prod_a;
			fcxm_pkg::D_FY_LD:  fy_q <= prod_a;
			fcxm_pkg::D_FY_ADD: fy_q <= fy_q + prod_a;
			fcxm_pkg::D_RR:     rr_q <= prod_a;
			default: ;
		endcase
		if (ctrl.emit) begin
			drv_q <= drv;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctrl.emit) begin
			vld_q <= 1'b1;
		end else if (out_ready) begin
			vld_q <= 1'b0;
		end
	end

	assign out_valid = vld_q;
	assign out_data  = drv_q;

endmodule

[rtl/field_centric_xdrive_mixer.sv]
// Channel   Dir  Transfer when              Payload
// s_*       in   s_tvalid & s_tready        one joystick frame (s_tdata)
// m_*       out  m_tvalid & m_tready        four motor drives (m_tdata)
// APB       in   psel & penable & pwrite    register write, pready tied high
//
// A frame is taken only at the idle step; eleven more steps on one shared
// multiplier then load the drives into the output register, and no new frame
// is taken until they are done. A finished result waits there while the next
// frame is taken; the last step stalls only while that register is full and
// not being read. Reset clears the step counter, output valid and speed mode,
// and loads field-centric on, gains 77 and 256.
module field_centric_xdrive_mixer (
	input  logic                            clk,
	input  logic                            arst_n,
	// stream in
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [7:0] left_x, [15:8] left_y, [23:16] right_x, [35:24] heading,
	// [36] speed_button_pressed, rest zero
	input  logic [fcxm_pkg::IN_W-1:0]       s_tdata,
	// stream out
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [7:0] front_left_drive, [15:8] front_right_drive,
	// [23:16] back_left_drive, [31:24] back_right_drive
	output logic [fcxm_pkg::OUT_W-1:0]      m_tdata,
	// configuration
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [fcxm_pkg::PADDR_W-1:0]    paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);

	logic                           fce_q;
	logic [fcxm_pkg::GAIN_W-1:0]    slow_gain_q, full_gain_q;
	logic                           slow_mode_q;
	logic                           slow_mode;
	logic [fcxm_pkg::GAIN_W-1:0]    gain;
	logic                           in_fire, cfg_wr;
	fcxm_pkg::ctrl_t                ctrl;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign s_tready = ctrl.in_ready;
	assign in_fire  = s_tvalid && s_tready;

	// register file; a write to an unused address is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fce_q       <= 1'b1;
			slow_gain_q <= fcxm_pkg::GAIN_W'(77);
			full_gain_q <= fcxm_pkg::GAIN_W'(256);
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				fcxm_pkg::REG_FCE:  fce_q       <= pwdata[0];
				fcxm_pkg::REG_SLOW: slow_gain_q <= pwdata[fcxm_pkg::GAIN_W-1:0];
				fcxm_pkg::REG_FULL: full_gain_q <= pwdata[fcxm_pkg::GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			fcxm_pkg::REG_FCE:  prdata = 32'(fce_q);
			fcxm_pkg::REG_SLOW: prdata = 32'(slow_gain_q);
			fcxm_pkg::REG_FULL: prdata = 32'(full_gain_q);
			default:            prdata = '0;
		endcase
	end

	// each frame taken with the press bit set toggles the mode; the new mode already scales this frame
	always_comb begin
		slow_mode = slow_mode_q ^ (in_fire && s_tdata[3*fcxm_pkg::AXIS_W + fcxm_pkg::ANGLE_BITS]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slow_mode_q <= 1'b0;
		end else begin
			slow_mode_q <= slow_mode;
		end
	end

	assign gain = slow_mode_q ? slow_gain_q : full_gain_q;

	fcxm_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.out_busy (m_tvalid && !m_tready),
		.ctrl     (ctrl)
	);

	fcxm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.in_fire   (in_fire),
		.in_data   (s_tdata),
		.gain      (gain),
		.fce       (fce_q),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_data  (m_tdata)
	);

endmodule

[rtl/fcxm_checker.sv]
module fcxm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// saturation keeps every drive within -127..127
	a_no_min: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[7:0] != 8'h80 && m_tdata[15:8] != 8'h80 &&
		             m_tdata[23:16] != 8'h80 && m_tdata[31:24] != 8'h80)
		else $error("drive out of range");

	// one frame at a time: no second transfer right after one
	a_one_frame: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while busy");

	// a taken frame never raises the output valid directly
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !$rose(m_tvalid))
		else $error("result too early");

endmodule

bind field_centric_xdrive_mixer fcxm_checker u_fcxm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
